>>> src/lljd_pkg.sv
// shared types and constants for the least-loaded job dispatcher
// no dependencies; used by lljd_load_mem, lljd_seq and least_loaded_job_dispatcher
package lljd_pkg;

   localparam int JOB_W   = 16;
   localparam int LOAD_W  = 32;
   localparam int SRV_W   = 3;
   localparam int CNT_W   = 4;
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;

   // register word indexes on the csr port
   localparam logic [0:0] REG_PRINTER_COUNT = 1'b0;

   localparam logic [CNT_W-1:0] PRINTER_COUNT_RST = 4'd8;

   // add that sticks at the all-ones maximum
   function automatic logic [LOAD_W-1:0] sat_add(input logic [LOAD_W-1:0] a,
                                                 input logic [LOAD_W-1:0] b);
      logic [LOAD_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[LOAD_W] ? {LOAD_W{1'b1}} : s[LOAD_W-1:0];
   endfunction

endpackage

>>> src/lljd_load_mem.sv
// per-server load memory: one write port, one registered read port
// entries read as zero until first written (valid bit per entry); uses lljd_pkg
module lljd_load_mem #(
   parameter int DEPTH = 8,
   parameter int AW    = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [AW-1:0]                 rd_addr,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [lljd_pkg::LOAD_W-1:0]   wr_data,
   output logic [lljd_pkg::LOAD_W-1:0]   rd_data
);
   import lljd_pkg::*;

   logic [LOAD_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [LOAD_W-1:0] rd_data_ff;
   logic              rd_valid_ff;

   // storage array, no reset
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // written flags, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // never-written entries read as zero load
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

>>> src/lljd_seq.sv
// job sequencer: scans loads for the minimum, writes back the sum, holds the result beat
// depends on lljd_pkg and lljd_load_mem
module lljd_seq #(
   parameter int NUM_SERVERS = 8,
   parameter int AW          = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [lljd_pkg::CNT_W-1:0]    printer_count,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [lljd_pkg::JOB_W-1:0]    req_job_pages,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lljd_pkg::SRV_W-1:0]    rsp_chosen_server,
   output logic [lljd_pkg::LOAD_W-1:0]   rsp_server_load,
   output logic [lljd_pkg::LOAD_W-1:0]   rsp_grand_total
);
   import lljd_pkg::*;

   localparam int CW = $clog2(NUM_SERVERS + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_WRITE} state_type;

   state_type         state_ff;
   logic [JOB_W-1:0]  pages_ff;
   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     rd_idx_ff;
   logic              cmp_vld_ff;
   logic [AW-1:0]     cmp_idx_ff;
   logic [AW-1:0]     best_idx_ff;
   logic [LOAD_W-1:0] best_load_ff;
   logic [LOAD_W-1:0] total_ff;
   logic              rsp_valid_ff;
   logic [SRV_W-1:0]  rsp_server_ff;
   logic [LOAD_W-1:0] rsp_load_ff;
   logic [LOAD_W-1:0] rsp_total_ff;

   logic [CW-1:0]     count_clamp;
   logic              rd_en;
   logic [LOAD_W-1:0] rd_data;
   logic              take;
   logic              last_cmp;
   logic              out_free;
   logic              write_go;
   logic              accept;
   logic [LOAD_W-1:0] load_sum;
   logic [LOAD_W-1:0] total_sum;

   lljd_load_mem #(
      .DEPTH (NUM_SERVERS),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .wr_en   (write_go),
      .wr_addr (best_idx_ff),
      .wr_data (load_sum),
      .rd_data (rd_data)
   );

   // active server count, zero counts as one, capped at the server number
   always_comb begin
      if (printer_count == '0) begin
         count_clamp = CW'(1);
      end else if (32'(printer_count) > NUM_SERVERS) begin
         count_clamp = CW'(NUM_SERVERS);
      end else begin
         count_clamp = CW'(printer_count);
      end
   end

   // scan and handshake control
   assign rd_en     = (state_ff == ST_SCAN) && (rd_idx_ff < count_ff);
   assign take      = (cmp_idx_ff == '0) || (rd_data < best_load_ff);
   assign last_cmp  = cmp_vld_ff && (CW'(cmp_idx_ff) == count_ff - CW'(1));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign write_go  = (state_ff == ST_WRITE) && out_free;
   assign req_stall = !((state_ff == ST_IDLE) || write_go);
   assign accept    = req_valid && !req_stall;

   // saturating updates
   assign load_sum  = sat_add(best_load_ff, LOAD_W'(pages_ff));
   assign total_sum = sat_add(total_ff, LOAD_W'(pages_ff));

   // state, scan registers and result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
      end else begin
         cmp_vld_ff <= rd_en;
         cmp_idx_ff <= rd_idx_ff[AW-1:0];
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  pages_ff  <= req_job_pages;
                  count_ff  <= count_clamp;
                  rd_idx_ff <= '0;
                  state_ff  <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (rd_en) begin
                  rd_idx_ff <= rd_idx_ff + CW'(1);
               end
               if (cmp_vld_ff && take) begin
                  best_idx_ff  <= cmp_idx_ff;
                  best_load_ff <= rd_data;
               end
               if (last_cmp) begin
                  state_ff <= ST_WRITE;
               end
            end
            ST_WRITE: begin
               if (write_go) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_server_ff <= SRV_W'(best_idx_ff);
                  rsp_load_ff   <= load_sum;
                  rsp_total_ff  <= total_sum;
                  total_ff      <= total_sum;
                  if (accept) begin
                     pages_ff  <= req_job_pages;
                     count_ff  <= count_clamp;
                     rd_idx_ff <= '0;
                     state_ff  <= ST_SCAN;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_chosen_server = rsp_server_ff;
   assign rsp_server_load   = rsp_load_ff;
   assign rsp_grand_total   = rsp_total_ff;

   // a write-back always loads a result beat
   a_write_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      write_go |=> rsp_valid_ff)
      else $error("write-back without result beat");

   // a load never exceeds the grand total
   a_load_le_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_load_ff <= rsp_total_ff))
      else $error("server load above grand total");

   // compared entries stay inside the active range
   a_cmp_in_range: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> (CW'(cmp_idx_ff) < count_ff))
      else $error("scan index outside active servers");

   // a new job never writes back in the cycle after it is taken
   a_no_early_write: assert property (@(posedge clock) disable iff (reset)
      accept |=> !write_go)
      else $error("write-back right after accept");

endmodule

>>> src/least_loaded_job_dispatcher.sv
// Least-loaded job dispatcher, top level: csr register and job sequencer.
// Each req beat carries one job's page count; the job goes to the active server
// with the smallest accumulated load (ties to the lowest index), and one rsp beat
// returns the chosen server, its new load and the running page total, both
// saturating at the 32-bit maximum.
// The loads are read one per cycle from a one-port-read memory: a job's scan reads
// N loads, N being the active count (printer_count, zero read as one, capped at
// NUM_SERVERS), then the sum is written back and the rsp beat registered. A new job
// can be taken in the write-back cycle.
// req_stall is low while the sequencer is idle or finishing a write-back.
// The result sits in an output register: a stalled rsp beat holds while the next
// job is already being scanned; write-back waits only if that register is still full.
// Reset clears all loads and the total and sets printer_count to 8; loads are
// never cleared afterwards, also not when printer_count changes.
// printer_count lives at byte address 0 of the APB port; pready is always high.
// Depends on lljd_pkg, lljd_seq and lljd_load_mem.
module least_loaded_job_dispatcher #(
   parameter int NUM_SERVERS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [lljd_pkg::PADDR_W-1:0]  paddr,
   input  logic [lljd_pkg::PDATA_W-1:0]  pwdata,
   output logic [lljd_pkg::PDATA_W-1:0]  prdata,
   output logic                          pready,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [lljd_pkg::JOB_W-1:0]    req_job_pages,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lljd_pkg::SRV_W-1:0]    rsp_chosen_server,
   output logic [lljd_pkg::LOAD_W-1:0]   rsp_server_load,
   output logic [lljd_pkg::LOAD_W-1:0]   rsp_grand_total
);
   import lljd_pkg::*;

   localparam int AW = $clog2(NUM_SERVERS);

   logic [CNT_W-1:0] printer_count_ff;
   logic             csr_write;
   logic [0:0]       reg_idx;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[PADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   // printer count register
   always_ff @(posedge clock) begin
      if (reset) begin
         printer_count_ff <= PRINTER_COUNT_RST;
      end else if (csr_write && (reg_idx == REG_PRINTER_COUNT)) begin
         printer_count_ff <= pwdata[CNT_W-1:0];
      end
   end

   // register readback
   always_comb begin
      if (reg_idx == REG_PRINTER_COUNT) begin
         prdata = PDATA_W'(printer_count_ff);
      end else begin
         prdata = '0;
      end
   end

   lljd_seq #(
      .NUM_SERVERS (NUM_SERVERS),
      .AW          (AW)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .printer_count     (printer_count_ff),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_job_pages     (req_job_pages),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_chosen_server (rsp_chosen_server),
      .rsp_server_load   (rsp_server_load),
      .rsp_grand_total   (rsp_grand_total)
   );

endmodule

>>> verif/lljd_checker.sv
// dispatch checker: follows the csr port and both beat channels, predicts each result
// depends on lljd_pkg; instantiated beside the dut by least_loaded_job_dispatcher_tb
module lljd_checker #(
   parameter int NUM_SERVERS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [lljd_pkg::PADDR_W-1:0]  paddr,
   input  logic [lljd_pkg::PDATA_W-1:0]  pwdata,
   input  logic [lljd_pkg::PDATA_W-1:0]  prdata,
   input  logic                          pready,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [lljd_pkg::JOB_W-1:0]    req_job_pages,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [lljd_pkg::SRV_W-1:0]    rsp_chosen_server,
   input  logic [lljd_pkg::LOAD_W-1:0]   rsp_server_load,
   input  logic [lljd_pkg::LOAD_W-1:0]   rsp_grand_total,
   output int                            fault_count,
   output int                            open_jobs
);
   timeunit 1ns;
   timeprecision 1ps;
   import lljd_pkg::*;

   localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

   typedef struct packed {
      logic [SRV_W-1:0]  server;
      logic [LOAD_W-1:0] load;
      logic [LOAD_W-1:0] total;
   } dispatch_type;

   // shadow of the dut state
   logic [LOAD_W-1:0] server_load_q [NUM_SERVERS];
   logic [LOAD_W-1:0] page_total_q;
   logic [CNT_W-1:0]  count_reg;
   dispatch_type      due_dispatches [$];

   initial fault_count = 0;
   initial open_jobs = 0;

   // add that holds at the all-ones ceiling
   function automatic logic [LOAD_W-1:0] clamp_add(input logic [LOAD_W-1:0] a,
                                                   input logic [JOB_W-1:0]  b);
      return (a > LOAD_MAX - LOAD_W'(b)) ? LOAD_MAX : a + LOAD_W'(b);
   endfunction

   // pick the least loaded active server and book the job on it
   function automatic dispatch_type route_job(input logic [JOB_W-1:0] pages);
      int           active;
      int           pick;
      dispatch_type d;
      // zero count acts as one, counts past the server number are capped
      active = (count_reg == '0) ? 1 : int'(count_reg);
      if (active > NUM_SERVERS) active = NUM_SERVERS;
      pick = 0;
      for (int s = 1; s < active; s++) begin
         if (server_load_q[s] < server_load_q[pick]) pick = s;
      end
      server_load_q[pick] = clamp_add(server_load_q[pick], pages);
      page_total_q = clamp_add(page_total_q, pages);
      d.server = SRV_W'(pick);
      d.load = server_load_q[pick];
      d.total = page_total_q;
      return d;
   endfunction

   always @(posedge clock) begin : watch
      dispatch_type want;
      if (reset) begin
         for (int s = 0; s < NUM_SERVERS; s++) server_load_q[s] = '0;
         page_total_q = '0;
         count_reg = PRINTER_COUNT_RST;
         due_dispatches.delete();
         open_jobs <= 0;
      end else begin
         // register access; only index 0 exists
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr[PADDR_W-1:2] == REG_PRINTER_COUNT) count_reg = pwdata[CNT_W-1:0];
            end else if (paddr[PADDR_W-1:2] == REG_PRINTER_COUNT &&
                         prdata !== PDATA_W'(count_reg)) begin
               fault_count++;
               $display("%0t: printer_count read, expected %0d, got %0d",
                        $time, count_reg, prdata);
            end
         end
         // result beat against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (due_dispatches.size() == 0) begin
               fault_count++;
               $display("%0t: result beat with none due, expected nothing, got server %0d",
                        $time, rsp_chosen_server);
            end else begin
               want = due_dispatches.pop_front();
               if (rsp_chosen_server !== want.server) begin
                  fault_count++;
                  $display("%0t: chosen_server, expected %0d, got %0d",
                           $time, want.server, rsp_chosen_server);
               end
               if (rsp_server_load !== want.load) begin
                  fault_count++;
                  $display("%0t: server_load, expected %0d, got %0d",
                           $time, want.load, rsp_server_load);
               end
               if (rsp_grand_total !== want.total) begin
                  fault_count++;
                  $display("%0t: grand_total, expected %0d, got %0d",
                           $time, want.total, rsp_grand_total);
               end
            end
         end
         // job beat
         if (req_valid && !req_stall) due_dispatches.push_back(route_job(req_job_pages));
         open_jobs <= due_dispatches.size();
      end
   end

endmodule

>>> verif/least_loaded_job_dispatcher_tb.sv
// stimulus and verdict for least_loaded_job_dispatcher
// depends on lljd_pkg, the dut sources and lljd_checker
module least_loaded_job_dispatcher_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lljd_pkg::*;

   localparam logic [PADDR_W-1:0] PRINTER_COUNT_ADDR = PADDR_W'(4 * REG_PRINTER_COUNT);
   localparam logic [PADDR_W-1:0] SPARE_REG_ADDR     = PADDR_W'(4);
   localparam int                 CYCLE_LIMIT        = 600000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [PADDR_W-1:0]  paddr = '0;
   logic [PDATA_W-1:0]  pwdata = '0;
   logic [PDATA_W-1:0]  prdata;
   logic                pready;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [JOB_W-1:0]    req_job_pages = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [SRV_W-1:0]    rsp_chosen_server;
   logic [LOAD_W-1:0]   rsp_server_load;
   logic [LOAD_W-1:0]   rsp_grand_total;
   int                  fault_count;
   int                  open_jobs;
   int                  cycle_count = 0;

   // idling styles: 0 none, 1 full random, 2 occasional
   int                  gap_style = 0;
   int                  stall_style = 0;
   bit                  squeeze = 1'b0;

   always #6 clock = ~clock;

   least_loaded_job_dispatcher dut (
      .clock(clock), .reset(reset),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .req_valid(req_valid), .req_stall(req_stall), .req_job_pages(req_job_pages),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_chosen_server(rsp_chosen_server), .rsp_server_load(rsp_server_load),
      .rsp_grand_total(rsp_grand_total)
   );

   lljd_checker u_checker (
      .clock(clock), .reset(reset),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .req_valid(req_valid), .req_stall(req_stall), .req_job_pages(req_job_pages),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_chosen_server(rsp_chosen_server), .rsp_server_load(rsp_server_load),
      .rsp_grand_total(rsp_grand_total),
      .fault_count(fault_count), .open_jobs(open_jobs)
   );

   function automatic int draw_wait(input int style);
      unique case (style)
         1: begin
            return $urandom_range(0, 17);
         end
         2: begin
            return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
         end
         default: begin
            return 0;
         end
      endcase
   endfunction

   // page counts biased toward ties and extremes
   function automatic logic [JOB_W-1:0] draw_pages();
      unique case ($urandom_range(0, 3))
         0: begin
            return JOB_W'($urandom_range(0, 7));
         end
         1: begin
            return JOB_W'($urandom);
         end
         2: begin
            return $urandom_range(0, 1) ? '1 : '0;
         end
         default: begin
            return JOB_W'($urandom_range(0, 255));
         end
      endcase
   endfunction

   // one job beat, after an optional gap with valid low
   task automatic send_job(input logic [JOB_W-1:0] pages);
      int gap;
      gap = draw_wait(gap_style);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_job_pages <= pages;
      do @(posedge clock); while (req_stall);
   endtask

   // drop valid and wait until every predicted result has come back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (open_jobs != 0) @(posedge clock);
   endtask

   // setup then access cycle on the csr port
   task automatic csr_access(input bit is_write, input logic [PADDR_W-1:0] addr,
                             input logic [PDATA_W-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= is_write;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // random upper bits around the count field
   task automatic set_count(input logic [CNT_W-1:0] cnt);
      csr_access(1'b1, PRINTER_COUNT_ADDR,
                 (PDATA_W'($urandom) & ~PDATA_W'({CNT_W{1'b1}})) | PDATA_W'(cnt));
      csr_access(1'b0, PRINTER_COUNT_ADDR, '0);
   endtask

   // result side: random hold-offs, one long hold when asked
   initial begin : result_side
      int hold;
      do @(posedge clock); while (reset);
      forever begin
         if (squeeze) begin
            hold = 200;
            squeeze = 1'b0;
         end else begin
            hold = draw_wait(stall_style);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("least_loaded_job_dispatcher_tb: done, errors");
         $finish;
      end
   end

   initial begin : job_side
      logic [CNT_W-1:0] cnt;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset count of eight: all-zero ties, field extremes, alternating bits
      send_job('0);
      send_job('1);
      send_job(16'd1);
      send_job('1);
      send_job(16'h5555);
      send_job(16'hAAAA);
      send_job(16'h8000);
      send_job(16'h7FFF);
      send_job('0);
      send_job(16'd3);
      settle();
      csr_access(1'b0, PRINTER_COUNT_ADDR, '0);

      // single server
      set_count(4'd1);
      send_job(16'd10);
      send_job(16'd20);
      settle();
      // zero count acts as one
      set_count(4'd0);
      send_job(16'd5);
      send_job('1);
      settle();
      // counts past the server number are capped
      set_count(4'd15);
      send_job(16'd7);
      send_job(16'd7);
      settle();
      set_count(4'd9);
      send_job(16'd1);
      settle();
      // write to an unknown index is ignored
      csr_access(1'b1, SPARE_REG_ADDR, 32'h0000_0002);
      csr_access(1'b0, PRINTER_COUNT_ADDR, '0);
      send_job(16'd2);
      send_job(16'd2);
      settle();
      // shrink to two servers: idle servers keep their loads
      set_count(4'd2);
      send_job(16'd4);
      send_job(16'd4);
      settle();

      // random phases
      for (int p = 0; p < 14; p++) begin
         unique case (p)
            0: cnt = 4'd8;
            1: cnt = 4'd1;
            2: cnt = 4'd8;
            3: cnt = 4'd0;
            4: cnt = 4'd15;
            default: cnt = CNT_W'($urandom_range(0, 15));
         endcase
         set_count(cnt);
         if ($urandom_range(0, 2) == 0) csr_access(1'b1, SPARE_REG_ADDR, $urandom);
         gap_style = p % 3;
         stall_style = $urandom_range(0, 2);
         // back-to-back jobs against a long result hold-off
         if (p == 2) begin
            gap_style = 0;
            squeeze = 1'b1;
         end
         repeat (130) send_job(draw_pages());
         settle();
      end

      repeat (12) @(posedge clock);
      if (fault_count == 0) begin
         $display("least_loaded_job_dispatcher_tb: done, clean");
      end else begin
         $display("least_loaded_job_dispatcher_tb: done, errors");
      end
      $finish;
   end

endmodule
